>>> sv/bbrc_pkg.sv
package bbrc_pkg;

  localparam int unsigned TagW    = 64;
  localparam int unsigned HandleW = 32;
  localparam int unsigned SizeW   = 40;
  localparam int unsigned HintW   = 32;
  localparam int unsigned BoxW    = 16;
  localparam int unsigned TotalW  = 45;
  localparam int unsigned DropW   = 5;
  localparam int unsigned ModeW   = 3;

  localparam logic [SizeW-1:0] BudgetReset = 40'd536870912;

  typedef enum logic [ModeW-1:0] {
    MODE_TAKE_SET = 3'd0,
    MODE_TAKE_INT = 3'd1,
    MODE_PUT_SET  = 3'd2,
    MODE_PUT_INT  = 3'd3,
    MODE_CLEAR    = 3'd4
  } mode_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the item and search the table
    logic promote;   // move or insert the keyed entry at the newest place
    logic drop_old;  // remove the oldest entry
    logic clear;     // empty the table
    logic lookup;    // evaluate the take result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_take;
    logic is_put;
    logic is_clear;
    logic over;      // more than one entry and resident above budget
  } stat_t;

endpackage

>>> sv/bbrc_datapath.sv
module bbrc_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bbrc_pkg::cmd_t               cmd_i,
  output bbrc_pkg::stat_t              stat_o,
  input  logic [bbrc_pkg::SizeW-1:0]   budget_i,
  input  logic [bbrc_pkg::ModeW-1:0]   mode_i,
  input  logic [bbrc_pkg::TagW-1:0]    key_tag_i,
  input  logic [bbrc_pkg::BoxW-1:0]    box_width_i,
  input  logic [bbrc_pkg::BoxW-1:0]    box_height_i,
  input  logic [bbrc_pkg::HandleW-1:0] image_handle_i,
  input  logic [bbrc_pkg::SizeW-1:0]   image_size_i,
  input  logic [bbrc_pkg::HintW-1:0]   hint_in_i,
  output logic                         hit_o,
  output logic [bbrc_pkg::HandleW-1:0] image_out_o,
  output logic [bbrc_pkg::HintW-1:0]   hint_out_o,
  output logic [bbrc_pkg::TotalW-1:0]  resident_total_o,
  output logic [bbrc_pkg::DropW-1:0]   dropped_count_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [CntW-1:0] Full = CntW'(ENTRIES);

  logic [bbrc_pkg::TagW-1:0]    tag_q    [ENTRIES];
  logic [bbrc_pkg::HandleW-1:0] s_hdl_q  [ENTRIES];
  logic [bbrc_pkg::SizeW-1:0]   s_size_q [ENTRIES];
  logic [bbrc_pkg::HintW-1:0]   s_hint_q [ENTRIES];
  logic [bbrc_pkg::HandleW-1:0] l_hdl_q  [ENTRIES];
  logic [bbrc_pkg::SizeW-1:0]   l_size_q [ENTRIES];
  logic [bbrc_pkg::HintW-1:0]   l_hint_q [ENTRIES];
  logic [bbrc_pkg::BoxW-1:0]    l_bw_q   [ENTRIES];
  logic [bbrc_pkg::BoxW-1:0]    l_bh_q   [ENTRIES];
  logic [ENTRIES-1:0]           valid_q;
  logic [CntW-1:0]              count_q;
  logic [bbrc_pkg::TotalW-1:0]  total_q;
  logic [bbrc_pkg::DropW-1:0]   drop_q;

  logic [bbrc_pkg::ModeW-1:0]   mode_q;
  logic [bbrc_pkg::TagW-1:0]    key_q;
  logic [bbrc_pkg::BoxW-1:0]    bw_q, bh_q;
  logic [bbrc_pkg::HandleW-1:0] hdl_q;
  logic [bbrc_pkg::SizeW-1:0]   size_q;
  logic [bbrc_pkg::HintW-1:0]   hint_q;
  logic                         found_q;
  logic [IdxW-1:0]              pos_q;
  logic                         hit_q;
  logic [bbrc_pkg::HandleW-1:0] img_q;
  logic [bbrc_pkg::HintW-1:0]   hout_q;

  // parallel tag match, priority to the oldest
  logic [ENTRIES-1:0] match;
  logic               found_d;
  logic [IdxW-1:0]    pos_d;
  always_comb begin
    found_d = 1'b0;
    pos_d   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (tag_q[i] == key_tag_i);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_d = 1'b1;
        pos_d   = IdxW'(i);
      end
    end
  end

  logic is_take, is_put;
  assign is_take = (mode_q == bbrc_pkg::MODE_TAKE_SET) || (mode_q == bbrc_pkg::MODE_TAKE_INT);
  assign is_put  = ((mode_q == bbrc_pkg::MODE_PUT_SET) || (mode_q == bbrc_pkg::MODE_PUT_INT))
                   && (hdl_q != '0);
  assign stat_o.is_take  = is_take;
  assign stat_o.is_put   = is_put;
  assign stat_o.is_clear = (mode_q == bbrc_pkg::MODE_CLEAR);
  assign stat_o.over     = (count_q > CntW'(1)) && (total_q > bbrc_pkg::TotalW'(budget_i));

  // promotion: shift down everything after the removed place, write at the tail
  logic            full_new;
  logic [IdxW-1:0] rm_pos;
  logic [CntW-1:0] tail;
  logic [bbrc_pkg::TotalW-1:0] old_sz, rm_sz, new_sz;
  assign full_new = !found_q && (count_q == Full);
  assign rm_pos   = found_q ? pos_q : '0;
  assign tail     = (found_q || full_new) ? count_q - CntW'(1) : count_q;
  assign old_sz   = bbrc_pkg::TotalW'(s_size_q[0]) + bbrc_pkg::TotalW'(l_size_q[0]);
  assign rm_sz    = bbrc_pkg::TotalW'(s_size_q[rm_pos]) + bbrc_pkg::TotalW'(l_size_q[rm_pos]);
  assign new_sz   = bbrc_pkg::TotalW'(size_q);

  // size of the slot being overwritten in the moved entry
  logic [bbrc_pkg::TotalW-1:0] repl_sz;
  assign repl_sz = !found_q ? '0 :
                   (mode_q == bbrc_pkg::MODE_PUT_SET) ? bbrc_pkg::TotalW'(s_size_q[pos_q])
                                                      : bbrc_pkg::TotalW'(l_size_q[pos_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      total_q <= '0;
      drop_q  <= '0;
      hit_q   <= 1'b0;
      img_q   <= '0;
      hout_q  <= '0;
      mode_q  <= '0;
      hdl_q   <= '0;
      found_q <= 1'b0;
      pos_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        s_hdl_q[i]  <= '0;
        s_size_q[i] <= '0;
        l_hdl_q[i]  <= '0;
        l_size_q[i] <= '0;
        l_bw_q[i]   <= '0;
        l_bh_q[i]   <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        mode_q  <= mode_i;
        key_q   <= key_tag_i;
        bw_q    <= box_width_i;
        bh_q    <= box_height_i;
        hdl_q   <= image_handle_i;
        size_q  <= image_size_i;
        hint_q  <= hint_in_i;
        found_q <= found_d;
        pos_q   <= pos_d;
        drop_q  <= '0;
        hit_q   <= 1'b0;
        img_q   <= '0;
        hout_q  <= '0;
      end
      if (cmd_i.clear) begin
        valid_q <= '0;
        count_q <= '0;
        total_q <= '0;
        for (int i = 0; i < ENTRIES; i++) begin
          s_hdl_q[i]  <= '0;
          s_size_q[i] <= '0;
          l_hdl_q[i]  <= '0;
          l_size_q[i] <= '0;
          l_bw_q[i]   <= '0;
          l_bh_q[i]   <= '0;
        end
      end
      if (cmd_i.promote) begin
        for (int i = 0; i < ENTRIES - 1; i++) begin
          if ((found_q || full_new) && (IdxW'(i) >= rm_pos) && (CntW'(i) != tail)) begin
            tag_q[i]    <= tag_q[i+1];
            s_hdl_q[i]  <= s_hdl_q[i+1];
            s_size_q[i] <= s_size_q[i+1];
            s_hint_q[i] <= s_hint_q[i+1];
            l_hdl_q[i]  <= l_hdl_q[i+1];
            l_size_q[i] <= l_size_q[i+1];
            l_hint_q[i] <= l_hint_q[i+1];
            l_bw_q[i]   <= l_bw_q[i+1];
            l_bh_q[i]   <= l_bh_q[i+1];
          end
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (CntW'(i) == tail) begin
            tag_q[i]   <= key_q;
            valid_q[i] <= 1'b1;
            // fill the addressed slot, carry the other one over from the moved entry
            if (mode_q == bbrc_pkg::MODE_PUT_SET) begin
              s_hdl_q[i]  <= hdl_q;
              s_size_q[i] <= size_q;
              s_hint_q[i] <= hint_q;
              l_hdl_q[i]  <= found_q ? l_hdl_q[pos_q] : '0;
              l_size_q[i] <= found_q ? l_size_q[pos_q] : '0;
              l_hint_q[i] <= l_hint_q[pos_q];
              l_bw_q[i]   <= found_q ? l_bw_q[pos_q] : '0;
              l_bh_q[i]   <= found_q ? l_bh_q[pos_q] : '0;
            end else begin
              s_hdl_q[i]  <= found_q ? s_hdl_q[pos_q] : '0;
              s_size_q[i] <= found_q ? s_size_q[pos_q] : '0;
              s_hint_q[i] <= s_hint_q[pos_q];
              l_hdl_q[i]  <= hdl_q;
              l_size_q[i] <= size_q;
              l_hint_q[i] <= hint_q;
              l_bw_q[i]   <= bw_q;
              l_bh_q[i]   <= bh_q;
            end
          end
        end
        count_q <= tail + CntW'(1);
        if (found_q) begin
          total_q <= total_q - repl_sz + new_sz;
        end else if (full_new) begin
          total_q <= total_q - old_sz + new_sz;
          drop_q  <= drop_q + bbrc_pkg::DropW'(1);
        end else begin
          total_q <= total_q + new_sz;
        end
      end
      if (cmd_i.drop_old) begin
        for (int i = 0; i < ENTRIES - 1; i++) begin
          tag_q[i]    <= tag_q[i+1];
          s_hdl_q[i]  <= s_hdl_q[i+1];
          s_size_q[i] <= s_size_q[i+1];
          s_hint_q[i] <= s_hint_q[i+1];
          l_hdl_q[i]  <= l_hdl_q[i+1];
          l_size_q[i] <= l_size_q[i+1];
          l_hint_q[i] <= l_hint_q[i+1];
          l_bw_q[i]   <= l_bw_q[i+1];
          l_bh_q[i]   <= l_bh_q[i+1];
          valid_q[i]  <= valid_q[i+1];
        end
        s_hdl_q[ENTRIES-1]  <= '0;
        s_size_q[ENTRIES-1] <= '0;
        l_hdl_q[ENTRIES-1]  <= '0;
        l_size_q[ENTRIES-1] <= '0;
        l_bw_q[ENTRIES-1]   <= '0;
        l_bh_q[ENTRIES-1]   <= '0;
        valid_q[ENTRIES-1]  <= 1'b0;
        count_q <= count_q - CntW'(1);
        total_q <= total_q - old_sz;
        if (drop_q != '1) begin
          drop_q <= drop_q + bbrc_pkg::DropW'(1);
        end
      end
      if (cmd_i.lookup && found_d) begin
        // key presented again from the held item after trimming
        if (mode_q == bbrc_pkg::MODE_TAKE_SET) begin
          if (s_hdl_q[pos_d] != '0) begin
            hit_q  <= 1'b1;
            img_q  <= s_hdl_q[pos_d];
            hout_q <= s_hint_q[pos_d];
          end
        end else if ((l_hdl_q[pos_d] != '0) && (l_bw_q[pos_d] == bw_q)
                     && (l_bh_q[pos_d] == bh_q)) begin
          hit_q  <= 1'b1;
          img_q  <= l_hdl_q[pos_d];
          hout_q <= l_hint_q[pos_d];
        end
      end
    end
  end

  assign hit_o            = hit_q;
  assign image_out_o      = img_q;
  assign hint_out_o       = hout_q;
  assign resident_total_o = total_q;
  assign dropped_count_o  = drop_q;

endmodule

>>> sv/bbrc_ctrl.sv
module bbrc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output bbrc_pkg::cmd_t  cmd_o,
  input  bbrc_pkg::stat_t stat_i,
  output logic            lookup_sel_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_PROMO  = 6'b000100,
    ST_TRIM   = 6'b001000,
    ST_LOOK   = 6'b010000,
    ST_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat_i.is_put) begin
          cmd_o.promote = 1'b1;
          state_d       = ST_TRIM;
        end else if (stat_i.is_take) begin
          state_d = ST_TRIM;
        end else begin
          cmd_o.clear = stat_i.is_clear;
          state_d     = ST_OUT;
        end
      end
      ST_TRIM: begin
        // drop one oldest entry a cycle while over budget
        if (stat_i.over) begin
          cmd_o.drop_old = 1'b1;
        end else if (stat_i.is_take) begin
          state_d = ST_LOOK;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_d = ST_IDLE;
        end
      end
      ST_PROMO: begin
        state_d = ST_TRIM;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign lookup_sel_o = (state_q == ST_LOOK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/byte_budget_recency_cache.sv
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | mode, key tag, box, handle, size, hint
// out     | output    | out_valid/out_stall| hit, image, hint, resident total, dropped
// cfg     | input     | cfg_valid/cfg_ready| resident byte limit (40 bits)
// From acceptance an item passes DECIDE, then TRIM for a put or take, LOOK for a take only,
// and OUT; a clear or ignored item goes from DECIDE straight to OUT. The trim drops oldest
// entries (at most ENTRIES - 1) by a shift of the entry table, one entry a cycle.
// Reset empties the table and loads the budget with 512 MiB.
// A new item is taken only once the previous result has been delivered.
module byte_budget_recency_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bbrc_pkg::ModeW-1:0]   mode_i,
  input  logic [bbrc_pkg::TagW-1:0]    key_tag_i,
  input  logic [bbrc_pkg::BoxW-1:0]    box_width_i,
  input  logic [bbrc_pkg::BoxW-1:0]    box_height_i,
  input  logic [bbrc_pkg::HandleW-1:0] image_handle_i,
  input  logic [bbrc_pkg::SizeW-1:0]   image_size_i,
  input  logic [bbrc_pkg::HintW-1:0]   hint_in_i,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit_o,
  output logic [bbrc_pkg::HandleW-1:0] image_out_o,
  output logic [bbrc_pkg::HintW-1:0]   hint_out_o,
  output logic [bbrc_pkg::TotalW-1:0]  resident_total_o,
  output logic [bbrc_pkg::DropW-1:0]   dropped_count_o,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bbrc_pkg::SizeW-1:0]   cfg_data_i
);

  logic [bbrc_pkg::SizeW-1:0] budget_q;
  bbrc_pkg::cmd_t  cmd;
  bbrc_pkg::stat_t stat;
  logic            look_sel;
  logic [bbrc_pkg::TagW-1:0] key_mux;
  logic [bbrc_pkg::TagW-1:0] key_hold_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= bbrc_pkg::BudgetReset;
    end else if (cfg_valid && cfg_ready) begin
      budget_q <= cfg_data_i;
    end
  end

  // hold the key so the lookup after trimming searches the shifted table
  always_ff @(posedge clk_i) begin
    if (cmd.load) begin
      key_hold_q <= key_tag_i;
    end
  end
  assign key_mux = look_sel ? key_hold_q : key_tag_i;

  bbrc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd_o        (cmd),
    .stat_i       (stat),
    .lookup_sel_o (look_sel)
  );

  bbrc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .budget_i         (budget_q),
    .mode_i           (mode_i),
    .key_tag_i        (key_mux),
    .box_width_i      (box_width_i),
    .box_height_i     (box_height_i),
    .image_handle_i   (image_handle_i),
    .image_size_i     (image_size_i),
    .hint_in_i        (hint_in_i),
    .hit_o            (hit_o),
    .image_out_o      (image_out_o),
    .hint_out_o       (hint_out_o),
    .resident_total_o (resident_total_o),
    .dropped_count_o  (dropped_count_o)
  );

endmodule

>>> tb/sv/byte_budget_recency_cache_checker.sv
module byte_budget_recency_cache_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [bbrc_pkg::ModeW-1:0]   mode_i,
  input  logic [bbrc_pkg::TagW-1:0]    key_tag_i,
  input  logic [bbrc_pkg::BoxW-1:0]    box_width_i,
  input  logic [bbrc_pkg::BoxW-1:0]    box_height_i,
  input  logic [bbrc_pkg::HandleW-1:0] image_handle_i,
  input  logic [bbrc_pkg::SizeW-1:0]   image_size_i,
  input  logic [bbrc_pkg::HintW-1:0]   hint_in_i,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         hit_o,
  input  logic [bbrc_pkg::HandleW-1:0] image_out_o,
  input  logic [bbrc_pkg::HintW-1:0]   hint_out_o,
  input  logic [bbrc_pkg::TotalW-1:0]  resident_total_o,
  input  logic [bbrc_pkg::DropW-1:0]   dropped_count_o,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [bbrc_pkg::SizeW-1:0]   cfg_data_i,
  output int                           fail_count,
  output int                           pending,
  output int                           hit_seen,
  output int                           drop_seen
);

  localparam int Depth = 16;

  typedef struct packed {
    logic [bbrc_pkg::TagW-1:0]    tag;
    logic [bbrc_pkg::HandleW-1:0] s_handle;
    logic [bbrc_pkg::SizeW-1:0]   s_size;
    logic [bbrc_pkg::HintW-1:0]   s_hint;
    logic [bbrc_pkg::HandleW-1:0] l_handle;
    logic [bbrc_pkg::SizeW-1:0]   l_size;
    logic [bbrc_pkg::HintW-1:0]   l_hint;
    logic [bbrc_pkg::BoxW-1:0]    l_w;
    logic [bbrc_pkg::BoxW-1:0]    l_h;
  } line_t;

  typedef struct packed {
    logic                         hit;
    logic [bbrc_pkg::HandleW-1:0] image;
    logic [bbrc_pkg::HintW-1:0]   hint;
    logic [bbrc_pkg::TotalW-1:0]  total;
    logic [bbrc_pkg::DropW-1:0]   dropped;
  } answer_t;

  line_t       lines[Depth];
  int          used;
  logic [bbrc_pkg::SizeW-1:0] budget;
  answer_t     answers_due[$];

  function automatic logic [63:0] bytes_held();
    logic [63:0] s;
    s = 0;
    for (int i = 0; i < used; i++) s += lines[i].s_size + lines[i].l_size;
    return s;
  endfunction

  function automatic void evict(int pos);
    for (int i = pos; i < used - 1; i++) lines[i] = lines[i+1];
    used--;
    lines[used] = '0;
  endfunction

  function automatic int shrink();
    int n;
    n = 0;
    while (used > 1 && bytes_held() > budget) begin
      evict(0);
      n++;
    end
    return n;
  endfunction

  function automatic int locate(logic [bbrc_pkg::TagW-1:0] t);
    for (int i = 0; i < used; i++) if (lines[i].tag == t) return i;
    return -1;
  endfunction

  function automatic answer_t serve(logic [bbrc_pkg::ModeW-1:0] m,
                                    logic [bbrc_pkg::TagW-1:0] t,
                                    logic [bbrc_pkg::BoxW-1:0] w,
                                    logic [bbrc_pkg::BoxW-1:0] h,
                                    logic [bbrc_pkg::HandleW-1:0] hd,
                                    logic [bbrc_pkg::SizeW-1:0] sz,
                                    logic [bbrc_pkg::HintW-1:0] hn);
    answer_t a;
    int      p;
    int      n;
    line_t   ln;
    a = '0;
    n = 0;
    if (m == bbrc_pkg::MODE_TAKE_SET || m == bbrc_pkg::MODE_TAKE_INT) begin
      n = shrink();
      p = locate(t);
      if (p >= 0) begin
        ln = lines[p];
        if (m == bbrc_pkg::MODE_TAKE_SET) begin
          if (ln.s_handle != 0) begin
            a.hit = 1'b1; a.image = ln.s_handle; a.hint = ln.s_hint;
          end
        end else if (ln.l_handle != 0 && ln.l_w == w && ln.l_h == h) begin
          a.hit = 1'b1; a.image = ln.l_handle; a.hint = ln.l_hint;
        end
      end
    end else if ((m == bbrc_pkg::MODE_PUT_SET || m == bbrc_pkg::MODE_PUT_INT) && hd != 0) begin
      p = locate(t);
      if (p >= 0) begin
        ln = lines[p];
        evict(p);
      end else begin
        if (used >= Depth) begin
          evict(0);
          n++;
        end
        ln = '0;
        ln.tag = t;
      end
      if (m == bbrc_pkg::MODE_PUT_SET) begin
        ln.s_handle = hd; ln.s_size = sz; ln.s_hint = hn;
      end else begin
        ln.l_handle = hd; ln.l_size = sz; ln.l_hint = hn; ln.l_w = w; ln.l_h = h;
      end
      lines[used] = ln;
      used++;
      n += shrink();
    end else if (m == bbrc_pkg::MODE_CLEAR) begin
      for (int i = 0; i < Depth; i++) lines[i] = '0;
      used = 0;
    end
    a.dropped = (n > 31) ? 5'd31 : n[bbrc_pkg::DropW-1:0];
    a.total = bbrc_pkg::TotalW'(bytes_held());
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) lines[i] = '0;
      used = 0;
      budget = bbrc_pkg::BudgetReset;
      answers_due.delete();
      fail_count <= 0;
      pending <= 0;
      hit_seen <= 0;
      drop_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) budget = cfg_data_i;
      if (in_valid && !in_stall)
        answers_due = {answers_due, serve(mode_i, key_tag_i, box_width_i, box_height_i,
                                          image_handle_i, image_size_i, hint_in_i)};
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result with nothing expected", $time);
          fail_count <= fail_count + 1;
        end else begin
          want = answers_due.pop_front();
          if (hit_o) hit_seen <= hit_seen + 1;
          if (dropped_count_o != 0) drop_seen <= drop_seen + 1;
          if (want != {hit_o, image_out_o, hint_out_o, resident_total_o,
                       dropped_count_o}) begin
            $display("%0t: mismatch expected hit %0d image %h hint %h total %0d drop %0d",
                     $time, want.hit, want.image, want.hint, want.total, want.dropped);
            $display("%0t:          actual   hit %0d image %h hint %h total %0d drop %0d",
                     $time, hit_o, image_out_o, hint_out_o, resident_total_o,
                     dropped_count_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= answers_due.size();
    end
  end
endmodule

>>> tb/sv/byte_budget_recency_cache_test.sv
module byte_budget_recency_cache_test;

  logic                         clk_i = 0;
  logic                         rst_ni = 0;
  logic                         in_valid = 0;
  logic                         in_stall;
  logic [bbrc_pkg::ModeW-1:0]   mode_i = '0;
  logic [bbrc_pkg::TagW-1:0]    key_tag_i = '0;
  logic [bbrc_pkg::BoxW-1:0]    box_width_i = '0;
  logic [bbrc_pkg::BoxW-1:0]    box_height_i = '0;
  logic [bbrc_pkg::HandleW-1:0] image_handle_i = '0;
  logic [bbrc_pkg::SizeW-1:0]   image_size_i = '0;
  logic [bbrc_pkg::HintW-1:0]   hint_in_i = '0;
  logic                         out_valid;
  logic                         out_stall = 1;
  logic                         hit_o;
  logic [bbrc_pkg::HandleW-1:0] image_out_o;
  logic [bbrc_pkg::HintW-1:0]   hint_out_o;
  logic [bbrc_pkg::TotalW-1:0]  resident_total_o;
  logic [bbrc_pkg::DropW-1:0]   dropped_count_o;
  logic                         cfg_valid = 0;
  logic                         cfg_ready;
  logic [bbrc_pkg::SizeW-1:0]   cfg_data_i = '0;
  int                           fail_count, pending, hit_seen, drop_seen;

  int  idle_cycles;
  bit  calm;          // no idling in the final part
  bit  hold_off_req;
  int  items_sent;
  logic [bbrc_pkg::TagW-1:0] tag_pool[8];

  always #10 clk_i = ~clk_i;

  byte_budget_recency_cache dut (.*);
  byte_budget_recency_cache_checker watch (.*);

  // watchdog: count cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("byte_budget_recency_cache_test: errors");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall <= 1;
        for (n = 0; n < 300; n++) @(negedge clk_i);
        hold_off_req = 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1;
        n = $urandom_range(1, 17);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_stall <= 0;
      end
    end
  end

  // leaves valid high after the accepting edge; drain, or a random pause in the next call, drops it
  task automatic send(logic [bbrc_pkg::ModeW-1:0] m, logic [bbrc_pkg::TagW-1:0] t,
                      logic [bbrc_pkg::BoxW-1:0] w, logic [bbrc_pkg::BoxW-1:0] h,
                      logic [bbrc_pkg::HandleW-1:0] hd, logic [bbrc_pkg::SizeW-1:0] sz,
                      logic [bbrc_pkg::HintW-1:0] hn);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid <= 1;
    mode_i <= m; key_tag_i <= t; box_width_i <= w; box_height_i <= h;
    image_handle_i <= hd; image_size_i <= sz; hint_in_i <= hn;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_budget(logic [bbrc_pkg::SizeW-1:0] b);
    drain();
    cfg_valid <= 1;
    cfg_data_i <= b;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 0;
  endtask

  task automatic random_item(int big);
    int          r;
    logic [2:0]  m;
    logic [15:0] w, h;
    r = $urandom_range(0, 9);
    if (r == 9) m = 3'($urandom_range(5, 7));
    else if (r > 4) m = 3'($urandom_range(0, 3));
    else m = 3'(r);
    w = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1));
    h = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1));
    if ($urandom_range(0, 40) == 0) m = bbrc_pkg::MODE_CLEAR;
    send(m, $urandom_range(0, 9) == 0 ? {$urandom, $urandom}
                                      : tag_pool[$urandom_range(0, 7)],
         w, h, $urandom_range(0, 9) == 0 ? 32'd0 : $urandom,
         big ? 40'({$urandom, $urandom}) : 40'($urandom_range(0, 300)), $urandom);
  endtask

  initial begin
    calm = 0;
    hold_off_req = 0;
    items_sent = 0;
    for (int i = 0; i < 8; i++) tag_pool[i] = {$urandom, $urandom};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: extremes, every mode, zero handle, overwrite, full table, clear
    send(bbrc_pkg::MODE_TAKE_SET, '0, '0, '0, '0, '0, '0);
    send(bbrc_pkg::MODE_PUT_SET, '1, '1, '1, '1, '1, '1);
    send(bbrc_pkg::MODE_TAKE_SET, '1, '0, '0, '0, '0, '0);
    send(bbrc_pkg::MODE_PUT_INT, '1, 16'hffff, 16'h0, 32'h5, 40'd10, 32'h77);
    send(bbrc_pkg::MODE_TAKE_INT, '1, 16'hffff, 16'h0, '0, '0, '0);
    send(bbrc_pkg::MODE_TAKE_INT, '1, 16'hffff, 16'h1, '0, '0, '0);
    send(bbrc_pkg::MODE_PUT_SET, '0, '0, '0, '0, 40'd5, 32'h1);
    send(bbrc_pkg::MODE_PUT_SET, 64'h1, '0, '0, 32'h9, 40'd100, 32'h2);
    send(bbrc_pkg::MODE_PUT_SET, 64'h1, '0, '0, 32'ha, 40'd7, 32'h3);
    send(bbrc_pkg::MODE_TAKE_SET, 64'h1, '0, '0, '0, '0, '0);
    send(3'd5, 64'h1, '0, '0, '0, '0, '0);
    send(3'd7, 64'h1, '0, '0, '0, '0, '0);
    send(bbrc_pkg::MODE_CLEAR, '0, '0, '0, '0, '0, '0);
    for (int i = 0; i < 18; i++)
      send(bbrc_pkg::MODE_PUT_SET, 64'(i + 100), '0, '0, 32'(i + 1), 40'd1, 32'(i));
    set_budget('0);
    send(bbrc_pkg::MODE_TAKE_SET, 64'd117, '0, '0, '0, '0, '0);
    set_budget('1);

    // random phases across budgets
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_budget(40'd1000);
        1: set_budget(40'd0);
        2: set_budget(40'd300);
        3: set_budget('1);
        default: set_budget(bbrc_pkg::BudgetReset);
      endcase
      if (ph == 2) hold_off_req = 1;
      for (int i = 0; i < 90; i++) random_item(ph == 3 || ph == 4);
    end
    drain();   // sender pauses until all results are in
    set_budget(40'd500);
    calm = 1;
    for (int i = 0; i < 60; i++) random_item(0);
    drain();
    $display("Sent %0d items across several budget settings; %0d hits, %0d results with drops.",
             items_sent, hit_seen, drop_seen);
    if (fail_count == 0)
      $display("byte_budget_recency_cache_test: clean");
    else
      $display("byte_budget_recency_cache_test: errors");
    $finish;
  end
endmodule

>>> filelist.f
sv/bbrc_pkg.sv
sv/bbrc_datapath.sv
sv/bbrc_ctrl.sv
sv/byte_budget_recency_cache.sv
tb/sv/byte_budget_recency_cache_checker.sv
tb/sv/byte_budget_recency_cache_test.sv
